/* hw/rtl/tqv_pkg.sv */
`default_nettype none

package tqv_pkg;

	// sizing limits of the block
	localparam int MAX_MAP_COLUMNS = 1024;
	localparam int MAX_MAP_ROWS    = 1024;
	localparam int MAX_TILE_PIXELS = 256;
	localparam int TILE_INDEX_BITS = 16;
	localparam int ATLAS_MAX_TILES = 1024;

	// field and register widths
	localparam int TILE_INDEX_W = 16;
	localparam int CORNER_W     = 2;
	localparam int SCREEN_W     = 19;
	localparam int TEXU_W       = 19;
	localparam int TEXV_W       = 25;
	localparam int TILE_REG_W   = 9;
	localparam int MAP_REG_W    = 11;

	// apb register map
	localparam int CFG_IDX_W  = 3;
	localparam int APB_ADDR_W = CFG_IDX_W + 2;
	localparam int APB_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TILE_WIDTH       = 3'd0,
		REG_TILE_HEIGHT      = 3'd1,
		REG_ATLAS_TILES_WIDE = 3'd2,
		REG_MAP_COLUMNS      = 3'd3,
		REG_MAP_ROWS         = 3'd4
	} reg_idx_t;

	// derived internal widths
	localparam int COL_W   = (MAX_MAP_COLUMNS > 1) ? $clog2(MAX_MAP_COLUMNS) : 1;
	localparam int ROW_W   = (MAX_MAP_ROWS > 1) ? $clog2(MAX_MAP_ROWS) : 1;
	localparam int COLS_W  = $clog2(MAX_MAP_COLUMNS + 1);
	localparam int ROWS_W  = $clog2(MAX_MAP_ROWS + 1);
	localparam int TPIX_W  = $clog2(MAX_TILE_PIXELS + 1);
	localparam int AW_W    = $clog2(ATLAS_MAX_TILES + 1);
	localparam int IDX_W   = (TILE_INDEX_BITS < TILE_INDEX_W) ? TILE_INDEX_BITS : TILE_INDEX_W;
	localparam int X_PROD_W = COL_W + TPIX_W;
	localparam int Y_PROD_W = ROW_W + TPIX_W;
	localparam int U_PROD_W = AW_W + TPIX_W;
	localparam int V_PROD_W = IDX_W + TPIX_W;

	// divider: quotient bits resolved per cycle
	localparam int DIV_BITS   = 8;
	localparam int DIV_CYCLES = (IDX_W + DIV_BITS - 1) / DIV_BITS;
	localparam int DIVD_W     = DIV_CYCLES * DIV_BITS;
	localparam int STEP_W     = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

	// queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [CORNER_W-1:0] {
		CORNER_TL = 2'd0,
		CORNER_TR = 2'd1,
		CORNER_BR = 2'd2,
		CORNER_BL = 2'd3
	} corner_t;

	typedef enum logic [1:0] {
		DV_IDLE,
		DV_DIV,
		DV_SCALE,
		DV_HOLD
	} div_state_t;

	// effective configuration after clamping
	typedef struct packed {
		logic [TPIX_W-1:0] tw;
		logic [TPIX_W-1:0] th;
		logic [AW_W-1:0]   aw;
		logic [COLS_W-1:0] cols;
		logic [ROWS_W-1:0] rows;
	} cfg_t;

	// tile request classified by the front
	typedef struct packed {
		logic [IDX_W-1:0]    idx;
		logic [SCREEN_W-1:0] x0;
		logic [SCREEN_W-1:0] y0;
		logic                map_end;
	} tile_cmd_t;

	// fully resolved quad origin
	typedef struct packed {
		logic [SCREEN_W-1:0] x0;
		logic [SCREEN_W-1:0] y0;
		logic [TEXU_W-1:0]   u0;
		logic [TEXV_W-1:0]   v0;
		logic                map_end;
	} quad_t;

endpackage

`default_nettype wire

/* hw/rtl/tqv_tile_if.sv */
`default_nettype none

interface tqv_tile_if import tqv_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [TILE_INDEX_W-1:0] tile_index;

	modport source (output valid, output tile_index, input ready);
	modport sink (input valid, input tile_index, output ready);
endinterface

`default_nettype wire

/* hw/rtl/tqv_vertex_if.sv */
`default_nettype none

interface tqv_vertex_if import tqv_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [CORNER_W-1:0] corner;
	logic [SCREEN_W-1:0] screen_x;
	logic [SCREEN_W-1:0] screen_y;
	logic [TEXU_W-1:0]   texel_u;
	logic [TEXV_W-1:0]   texel_v;
	logic                quad_done;
	logic                map_done;

	modport source (output valid, output corner, output screen_x, output screen_y,
		output texel_u, output texel_v, output quad_done, output map_done, input ready);
	modport sink (input valid, input corner, input screen_x, input screen_y,
		input texel_u, input texel_v, input quad_done, input map_done, output ready);
endinterface

`default_nettype wire

/* hw/rtl/tqv_front.sv */
`default_nettype none

module tqv_front import tqv_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	tqv_tile_if.sink   tile_in,
	input  cfg_t       cfg,
	input  logic       q_full,
	output logic       push,
	output tile_cmd_t  cmd
);

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic             last_col;
	logic             last_row;

	// take a request whenever the queue has room
	assign tile_in.ready = !q_full;
	assign push          = tile_in.valid && !q_full;

	// end of row and end of map
	assign last_col = (COLS_W'(col_q) + COLS_W'(1)) >= cfg.cols;
	assign last_row = (ROWS_W'(row_q) + ROWS_W'(1)) >= cfg.rows;

	// screen origin of this cell
	always_comb begin
		cmd.idx     = tile_in.tile_index[IDX_W-1:0];
		cmd.x0      = SCREEN_W'(X_PROD_W'(col_q) * X_PROD_W'(cfg.tw));
		cmd.y0      = SCREEN_W'(Y_PROD_W'(row_q) * Y_PROD_W'(cfg.th));
		cmd.map_end = last_col && last_row;
	end

	// raster position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (push) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : ROW_W'(row_q + ROW_W'(1));
			end else begin
				col_q <= COL_W'(col_q + COL_W'(1));
			end
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/tqv_queue.sv */
`default_nettype none

module tqv_queue import tqv_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  tile_cmd_t push_data,
	input  logic      pop,
	output logic      full,
	output logic      valid,
	output tile_cmd_t head
);

	tile_cmd_t         mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full  = count_q == QCNT_W'(QUEUE_DEPTH);
	assign valid = count_q != '0;
	assign head  = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= QPTR_W'(wr_ptr_q + QPTR_W'(1));
			end
			if (pop) begin
				rd_ptr_q <= QPTR_W'(rd_ptr_q + QPTR_W'(1));
			end
			case ({push, pop})
				2'b10:   count_q <= QCNT_W'(count_q + QCNT_W'(1));
				2'b01:   count_q <= QCNT_W'(count_q - QCNT_W'(1));
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/tqv_atlas_div.sv */
`default_nettype none

module tqv_atlas_div import tqv_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      cmd_valid,
	input  tile_cmd_t cmd,
	output logic      pop,
	output logic      quad_valid,
	output quad_t     quad,
	input  logic      take
);

	div_state_t        state_q;
	div_state_t        state_d;
	logic [STEP_W-1:0] step_q;
	logic [DIVD_W-1:0] dvd_q;
	logic [AW_W-1:0]   rem_q;
	logic [DIVD_W-1:0] dvd_d;
	logic [AW_W-1:0]   rem_d;
	logic              last_step;
	quad_t             quad_q;

	assign last_step = step_q == STEP_W'(DIV_CYCLES - 1);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			DV_IDLE: begin
				if (cmd_valid) begin
					state_d = DV_DIV;
				end
			end
			DV_DIV: begin
				if (last_step) begin
					state_d = DV_SCALE;
				end
			end
			DV_SCALE: state_d = DV_HOLD;
			DV_HOLD: begin
				if (take) begin
					state_d = cmd_valid ? DV_DIV : DV_IDLE;
				end
			end
			default: state_d = DV_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		pop        = 1'b0;
		quad_valid = 1'b0;
		case (state_q)
			DV_IDLE: pop = cmd_valid;
			DV_HOLD: begin
				quad_valid = 1'b1;
				pop        = take && cmd_valid;
			end
			default: begin
				pop        = 1'b0;
				quad_valid = 1'b0;
			end
		endcase
	end

	assign quad = quad_q;

	// restoring division, several quotient bits per cycle
	always_comb begin
		logic [AW_W:0]     trial;
		logic [AW_W-1:0]   r;
		logic [DIVD_W-1:0] d;
		r = rem_q;
		d = dvd_q;
		for (int i = 0; i < DIV_BITS; i++) begin
			trial = {r, d[DIVD_W-1]};
			d     = {d[DIVD_W-2:0], 1'b0};
			if (trial >= {1'b0, cfg.aw}) begin
				trial = trial - {1'b0, cfg.aw};
				d[0]  = 1'b1;
			end
			r = trial[AW_W-1:0];
		end
		rem_d = r;
		dvd_d = d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DV_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (pop) begin
				step_q <= '0;
			end else if (state_q == DV_DIV) begin
				step_q <= STEP_W'(step_q + STEP_W'(1));
			end
		end
	end

	// payload: load, iterate, then scale by the tile size
	always_ff @(posedge clk) begin
		if (pop) begin
			dvd_q          <= DIVD_W'(cmd.idx);
			rem_q          <= '0;
			quad_q.x0      <= cmd.x0;
			quad_q.y0      <= cmd.y0;
			quad_q.map_end <= cmd.map_end;
		end else if (state_q == DV_DIV) begin
			dvd_q <= dvd_d;
			rem_q <= rem_d;
		end else if (state_q == DV_SCALE) begin
			quad_q.u0 <= TEXU_W'(U_PROD_W'(rem_q) * U_PROD_W'(cfg.tw));
			quad_q.v0 <= TEXV_W'(V_PROD_W'(dvd_q[IDX_W-1:0]) * V_PROD_W'(cfg.th));
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/tqv_emit.sv */
`default_nettype none

module tqv_emit import tqv_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  cfg_t         cfg,
	input  logic         quad_valid,
	input  quad_t        quad,
	output logic         take,
	tqv_vertex_if.source vertex_out
);

	logic    busy_q;
	corner_t corner_q;
	quad_t   quad_q;
	logic    free;
	logic    right;
	logic    bottom;

	// a new quad enters once the last corner leaves
	assign free = !busy_q || (vertex_out.ready && corner_q == CORNER_BL);
	assign take = quad_valid && free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			corner_q <= CORNER_TL;
		end else if (take) begin
			busy_q   <= 1'b1;
			corner_q <= CORNER_TL;
		end else if (busy_q && vertex_out.ready) begin
			if (corner_q == CORNER_BL) begin
				busy_q <= 1'b0;
			end else begin
				corner_q <= corner_t'(corner_q + CORNER_W'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			quad_q <= quad;
		end
	end

	// corner offsets
	assign right  = corner_q == CORNER_TR || corner_q == CORNER_BR;
	assign bottom = corner_q == CORNER_BR || corner_q == CORNER_BL;

	always_comb begin
		vertex_out.valid     = busy_q;
		vertex_out.corner    = corner_q;
		vertex_out.screen_x  = quad_q.x0 + (right ? SCREEN_W'(cfg.tw) : SCREEN_W'(0));
		vertex_out.screen_y  = quad_q.y0 + (bottom ? SCREEN_W'(cfg.th) : SCREEN_W'(0));
		vertex_out.texel_u   = quad_q.u0 + (right ? TEXU_W'(cfg.tw) : TEXU_W'(0));
		vertex_out.texel_v   = quad_q.v0 + (bottom ? TEXV_W'(cfg.th) : TEXV_W'(0));
		vertex_out.quad_done = corner_q == CORNER_BL;
		vertex_out.map_done  = corner_q == CORNER_BL && quad_q.map_end;
	end

endmodule

`default_nettype wire

/* hw/rtl/tilemap_quad_vertex_generator.sv */
`default_nettype none

// channel      dir  payload                                        per request
// tile_in      in   tile_index                                     one map cell
// vertex_out   out  corner, screen_x/y, texel_u/v, quad/map_done   one quad vertex
// apb          in   tile size, atlas width, map size               one register
//
// the atlas divider resolves 8 quotient bits a cycle in DV_DIV, then scales in
// DV_SCALE and holds in DV_HOLD until handoff; four vertices follow while the
// next queued tile divides. vertex_out goes valid once the emitter takes the quad.
// reset zeroes the column and row counters and loads the default configuration.
// a 2-entry queue lets the front keep taking tiles while vertex_out stalls.

module tilemap_quad_vertex_generator import tqv_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	tqv_tile_if.sink              tile_in,
	tqv_vertex_if.source          vertex_out
);

	logic [TILE_REG_W-1:0] tile_width_q;
	logic [TILE_REG_W-1:0] tile_height_q;
	logic [MAP_REG_W-1:0]  atlas_tiles_wide_q;
	logic [MAP_REG_W-1:0]  map_columns_q;
	logic [MAP_REG_W-1:0]  map_rows_q;
	reg_idx_t              reg_idx;
	logic                  cfg_write;
	cfg_t                  cfg;

	tile_cmd_t push_cmd;
	tile_cmd_t head_cmd;
	logic      push;
	logic      pop;
	logic      q_full;
	logic      q_valid;
	quad_t     quad;
	logic      quad_valid;
	logic      take;

	// register access
	assign pready    = 1'b1;
	assign reg_idx   = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
	assign cfg_write = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_width_q       <= TILE_REG_W'(16);
			tile_height_q      <= TILE_REG_W'(16);
			atlas_tiles_wide_q <= MAP_REG_W'(16);
			map_columns_q      <= MAP_REG_W'(32);
			map_rows_q         <= MAP_REG_W'(32);
		end else if (cfg_write) begin
			case (reg_idx)
				REG_TILE_WIDTH:       tile_width_q       <= pwdata[TILE_REG_W-1:0];
				REG_TILE_HEIGHT:      tile_height_q      <= pwdata[TILE_REG_W-1:0];
				REG_ATLAS_TILES_WIDE: atlas_tiles_wide_q <= pwdata[MAP_REG_W-1:0];
				REG_MAP_COLUMNS:      map_columns_q      <= pwdata[MAP_REG_W-1:0];
				REG_MAP_ROWS:         map_rows_q         <= pwdata[MAP_REG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_TILE_WIDTH:       prdata = APB_DATA_W'(tile_width_q);
			REG_TILE_HEIGHT:      prdata = APB_DATA_W'(tile_height_q);
			REG_ATLAS_TILES_WIDE: prdata = APB_DATA_W'(atlas_tiles_wide_q);
			REG_MAP_COLUMNS:      prdata = APB_DATA_W'(map_columns_q);
			REG_MAP_ROWS:         prdata = APB_DATA_W'(map_rows_q);
			default:              prdata = '0;
		endcase
	end

	// clamp to the supported ranges
	always_comb begin
		cfg.tw = (tile_width_q > MAX_TILE_PIXELS) ? TPIX_W'(MAX_TILE_PIXELS)
			: TPIX_W'(tile_width_q);
		cfg.th = (tile_height_q > MAX_TILE_PIXELS) ? TPIX_W'(MAX_TILE_PIXELS)
			: TPIX_W'(tile_height_q);
		if (atlas_tiles_wide_q == '0) begin
			cfg.aw = AW_W'(1);
		end else if (atlas_tiles_wide_q > ATLAS_MAX_TILES) begin
			cfg.aw = AW_W'(ATLAS_MAX_TILES);
		end else begin
			cfg.aw = AW_W'(atlas_tiles_wide_q);
		end
		if (map_columns_q == '0) begin
			cfg.cols = COLS_W'(1);
		end else if (map_columns_q > MAX_MAP_COLUMNS) begin
			cfg.cols = COLS_W'(MAX_MAP_COLUMNS);
		end else begin
			cfg.cols = COLS_W'(map_columns_q);
		end
		if (map_rows_q == '0) begin
			cfg.rows = ROWS_W'(1);
		end else if (map_rows_q > MAX_MAP_ROWS) begin
			cfg.rows = ROWS_W'(MAX_MAP_ROWS);
		end else begin
			cfg.rows = ROWS_W'(map_rows_q);
		end
	end

	// front: raster position and screen origin
	tqv_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.tile_in(tile_in),
		.cfg    (cfg),
		.q_full (q_full),
		.push   (push),
		.cmd    (push_cmd)
	);

	tqv_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_cmd),
		.pop      (pop),
		.full     (q_full),
		.valid    (q_valid),
		.head     (head_cmd)
	);

	// back: atlas coordinates, then vertex output
	tqv_atlas_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd_valid (q_valid),
		.cmd       (head_cmd),
		.pop       (pop),
		.quad_valid(quad_valid),
		.quad      (quad),
		.take      (take)
	);

	tqv_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.quad_valid(quad_valid),
		.quad      (quad),
		.take      (take),
		.vertex_out(vertex_out)
	);

	// checks
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("tile queue written while full");

	a_corner_order: assert property (@(posedge clk) disable iff (!arst_n)
		(vertex_out.valid && vertex_out.ready && vertex_out.corner != CORNER_BL)
		|=> (vertex_out.valid
			&& vertex_out.corner == CORNER_W'($past(vertex_out.corner) + CORNER_W'(1))))
		else $error("quad corners out of order");

	a_quad_held: assert property (@(posedge clk) disable iff (!arst_n)
		(quad_valid && !take) |=> (quad_valid && $stable(quad)))
		else $error("atlas result changed before handoff");

endmodule

`default_nettype wire
